[rtl/core/ctt_pkg.sv]
`timescale 1ns / 1ps

package ctt_pkg;

    // Results one input byte can cause at most.
    localparam int MAX_RESULTS = 3;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOS  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Token types
    localparam logic [1:0] TYPE_WORD   = 2'd0;
    localparam logic [1:0] TYPE_QUOTED = 2'd1;
    localparam logic [1:0] TYPE_DELIM  = 2'd2;

    // Input opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_SQ,
        MODE_DQ
    } mode_t;

    typedef enum logic [1:0] {
        CD_NONE,
        CD_COMMENT,
        CD_KEPT
    } cdec_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] token_char;
        logic [1:0] token_type;
        logic       last_of_run;
    } out_item_t;

    // All results of one input byte, slot 0 first.
    typedef struct packed {
        logic [1:0]                        count;
        out_item_t [MAX_RESULTS-1:0]       slot;
    } run_t;

endpackage

[rtl/core/ctt_front.sv]
`timescale 1ns / 1ps

module ctt_front
    import ctt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     enq_valid,
    output run_t     enq_run
);

    mode_t mode_reg, mode_next;
    cdec_t cd_reg, cd_next;
    logic  sq_par_reg, sq_par_next;
    logic  dq_par_reg, dq_par_next;
    logic  err_reg, err_next;
    logic  fin_reg, fin_next;

    logic       accept;
    logic [7:0] c;
    logic       is_blank, is_mid, is_quoted, is_word, hash_opens;
    run_t       run;

    function automatic out_item_t mk(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic [1:0] ttype);
        out_item_t r;
        r.result_kind = kind;
        r.token_char  = ch;
        r.token_type  = ttype;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign accept     = push && !q_full;
    assign c          = in_item.text_byte;
    assign is_blank   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign is_mid     = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
                        (c == CH_RPAREN) || (c == CH_COMMA) || (c == CH_SEMI) ||
                        (c == CH_COLON);
    assign is_quoted  = (mode_reg == MODE_SQ) || (mode_reg == MODE_DQ);
    assign is_word    = (mode_reg == MODE_WORD);
    // first hash on the line, not quoted: the rest of the line is a comment
    assign hash_opens = (c == CH_HASH) && (cd_reg == CD_NONE) && !(sq_par_reg || dq_par_reg);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        cd_next     = cd_reg;
        sq_par_next = sq_par_reg;
        dq_par_next = dq_par_reg;
        err_next    = err_reg;
        fin_next    = fin_reg;
        priority if (err_reg || fin_reg)
        begin
        end
        else if (in_item.opcode == OP_END)
        begin
            mode_next   = MODE_IDLE;
            cd_next     = CD_NONE;
            sq_par_next = 1'b0;
            dq_par_next = 1'b0;
            if (is_quoted)
                err_next = 1'b1;
            else
                fin_next = 1'b1;
        end
        else if (c == CH_CR)
        begin
        end
        else if (c == CH_LF)
        begin
            mode_next   = MODE_IDLE;
            cd_next     = CD_NONE;
            sq_par_next = 1'b0;
            dq_par_next = 1'b0;
            if (is_quoted)
                err_next = 1'b1;
        end
        else if (cd_reg == CD_COMMENT)
        begin
        end
        else if (hash_opens)
        begin
            cd_next   = CD_COMMENT;
            mode_next = MODE_IDLE;
            if (is_quoted)
                err_next = 1'b1;
        end
        else
        begin
            if ((c == CH_HASH) && (cd_reg == CD_NONE))
                cd_next = CD_KEPT;
            if (cd_reg == CD_NONE)
            begin
                if (c == CH_SQUOTE)
                    sq_par_next = !sq_par_reg;
                else if (c == CH_DQUOTE)
                    dq_par_next = !dq_par_reg;
            end
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if (is_blank)
                        mode_next = MODE_IDLE;
                    else if (c == CH_SQUOTE)
                        mode_next = MODE_SQ;
                    else if (c == CH_DQUOTE)
                        mode_next = MODE_DQ;
                    else if ((c == CH_AT) || is_mid)
                        mode_next = MODE_IDLE;
                    else
                        mode_next = MODE_WORD;
                end
                MODE_WORD:
                begin
                    if (is_blank || is_mid)
                        mode_next = MODE_IDLE;
                end
                MODE_SQ:
                begin
                    if (c == CH_SQUOTE)
                        mode_next = MODE_IDLE;
                end
                MODE_DQ:
                begin
                    if (c == CH_DQUOTE)
                        mode_next = MODE_IDLE;
                end
                default: mode_next = MODE_IDLE;
            endcase
        end
    end

    // results of this byte
    always_comb
    begin
        run = '0;
        priority if (err_reg)
        begin
            run.count   = 2'd1;
            run.slot[0] = mk(KIND_ERR, 8'd0, TYPE_WORD);
        end
        else if (fin_reg)
        begin
            run.count   = 2'd1;
            run.slot[0] = mk(KIND_EOS, 8'd0, TYPE_WORD);
        end
        else if (in_item.opcode == OP_END)
        begin
            if (is_quoted)
            begin
                run.count   = 2'd1;
                run.slot[0] = mk(KIND_ERR, 8'd0, TYPE_WORD);
            end
            else if (is_word)
            begin
                run.count   = 2'd2;
                run.slot[0] = mk(KIND_END, 8'd0, TYPE_WORD);
                run.slot[1] = mk(KIND_EOS, 8'd0, TYPE_WORD);
            end
            else
            begin
                run.count   = 2'd1;
                run.slot[0] = mk(KIND_EOS, 8'd0, TYPE_WORD);
            end
        end
        else if ((c == CH_CR) || (c != CH_LF && cd_reg == CD_COMMENT))
        begin
        end
        else if ((c == CH_LF) || hash_opens)
        begin
            if (is_quoted)
            begin
                run.count   = 2'd1;
                run.slot[0] = mk(KIND_ERR, 8'd0, TYPE_WORD);
            end
            else if (is_word)
            begin
                run.count   = 2'd1;
                run.slot[0] = mk(KIND_END, 8'd0, TYPE_WORD);
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    if ((c == CH_AT) || is_mid)
                    begin
                        run.count   = 2'd2;
                        run.slot[0] = mk(KIND_CHAR, c, TYPE_DELIM);
                        run.slot[1] = mk(KIND_END, 8'd0, TYPE_DELIM);
                    end
                    else if (!is_blank && c != CH_SQUOTE && c != CH_DQUOTE)
                    begin
                        run.count   = 2'd1;
                        run.slot[0] = mk(KIND_CHAR, c, TYPE_WORD);
                    end
                end
                MODE_WORD:
                begin
                    if (is_blank)
                    begin
                        run.count   = 2'd1;
                        run.slot[0] = mk(KIND_END, 8'd0, TYPE_WORD);
                    end
                    else if (is_mid)
                    begin
                        run.count   = 2'd3;
                        run.slot[0] = mk(KIND_END, 8'd0, TYPE_WORD);
                        run.slot[1] = mk(KIND_CHAR, c, TYPE_DELIM);
                        run.slot[2] = mk(KIND_END, 8'd0, TYPE_DELIM);
                    end
                    else
                    begin
                        run.count   = 2'd1;
                        run.slot[0] = mk(KIND_CHAR, c, TYPE_WORD);
                    end
                end
                MODE_SQ, MODE_DQ:
                begin
                    run.count = 2'd1;
                    if ((mode_reg == MODE_SQ && c == CH_SQUOTE) ||
                        (mode_reg == MODE_DQ && c == CH_DQUOTE))
                        run.slot[0] = mk(KIND_END, 8'd0, TYPE_QUOTED);
                    else
                        run.slot[0] = mk(KIND_CHAR, c, TYPE_QUOTED);
                end
                default: run.count = 2'd0;
            endcase
        end
        // mark the final result of the byte
        if (run.count != 2'd0)
            run.slot[SLOT_W'(run.count - 2'd1)].last_of_run = 1'b1;
    end

    assign enq_valid = accept && (run.count != 2'd0);
    assign enq_run   = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cd_reg     <= CD_NONE;
            sq_par_reg <= 1'b0;
            dq_par_reg <= 1'b0;
            err_reg    <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            cd_reg     <= cd_next;
            sq_par_reg <= sq_par_next;
            dq_par_reg <= dq_par_next;
            err_reg    <= err_next;
            fin_reg    <= fin_next;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("format error flag dropped");

    a_err_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_reg && fin_reg))
        else $error("error and end of stream both latched");
`endif

endmodule

[rtl/core/ctt_queue.sv]
`timescale 1ns / 1ps

module ctt_queue
    import ctt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic enq_valid,
    input  run_t enq_run,
    output logic q_full,
    output logic head_valid,
    output run_t head_run,
    input  logic deq
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_enq, do_deq;

    assign q_full     = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = entry_reg[rd_ptr_reg];
    assign do_enq     = enq_valid && !q_full;
    assign do_deq     = deq && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_deq)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_enq && !do_deq)
            count_next = count_reg + CNT_W'(1);
        else if (do_deq && !do_enq)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
            entry_reg[wr_ptr_reg] <= enq_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("run queue over depth");
`endif

endmodule

[rtl/core/ctt_back.sv]
`timescale 1ns / 1ps

module ctt_back
    import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  run_t      head_run,
    output logic      deq,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              take, at_last;

    assign empty    = !head_valid;
    assign out_item = head_run.slot[idx_reg];
    assign take     = pop && head_valid;
    assign at_last  = (idx_reg == SLOT_W'(head_run.count - 2'd1));
    assign deq      = take && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = at_last ? '0 : idx_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < SLOT_W'(head_run.count)))
        else $error("slot index beyond run length");
`endif

endmodule

[rtl/core/config_text_tokenizer_unit.sv]
`timescale 1ns / 1ps

// A taken byte's run is registered in the run queue; empty falls once it reaches the head.
// Throughput: one byte per cycle while the queue has room and each byte yields at most one
//   result; a byte yielding k results holds the port for k pops, and pops set the pace then.
// The run queue (DEPTH entries) lets the front keep taking bytes while results wait.
// Reset (rst_n low, asynchronous): between tokens, parities and comment state clear,
//   error and end-of-stream flags clear, run queue empties.

module config_text_tokenizer_unit
    import ctt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic enq_valid;
    run_t enq_run;
    logic q_full;
    logic head_valid;
    run_t head_run;
    logic deq;

    // Front: classify each byte, advance the tokenizer state, and build the
    // run of results it causes (zero to three beats).
    ctt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .q_full    (q_full),
        .enq_valid (enq_valid),
        .enq_run   (enq_run)
    );

    // Queue of runs: drop empty runs at the front, hold the rest here so the
    // front and the result side stall independently.
    ctt_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq_valid  (enq_valid),
        .enq_run    (enq_run),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head_run   (head_run),
        .deq        (deq)
    );

    // Back: hand out the head run one beat per pop, then release it.
    ctt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .deq        (deq),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

    // A byte is taken whenever the queue has room for its run.
    assign full = q_full;

endmodule

[tb/tokenizer_checker.sv]
`timescale 1ns / 1ps

module tokenizer_checker
    import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    output int        mismatches,
    output int        results_due
);

    mode_t     tok_mode;
    logic      sq_odd;
    logic      dq_odd;
    cdec_t     hash_state;
    logic      err_latched;
    logic      eos_seen;
    out_item_t byte_beats[$];   // beats caused by the byte being scanned
    out_item_t token_beats[$];  // predicted beats, oldest first
    out_item_t oldest;

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function automatic bit is_delim(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_COMMA || c == CH_SEMI || c == CH_COLON;
    endfunction

    function automatic void add_beat(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic [1:0] ttype);
        out_item_t b;
        b.result_kind = kind;
        b.token_char  = ch;
        b.token_type  = ttype;
        b.last_of_run = 1'b0;
        byte_beats.push_back(b);
    endfunction

    function automatic void clear_line();
        tok_mode   = MODE_IDLE;
        sq_odd     = 1'b0;
        dq_odd     = 1'b0;
        hash_state = CD_NONE;
    endfunction

    // Line state no longer matters once the error is latched.
    function automatic void latch_error();
        err_latched = 1'b1;
        clear_line();
        add_beat(KIND_ERR, 8'h00, TYPE_WORD);
    endfunction

    function automatic void tokenize_step(input in_item_t it);
        logic [7:0] c;
        bit         quoted;
        c      = it.text_byte;
        quoted = (tok_mode == MODE_SQ) || (tok_mode == MODE_DQ);
        byte_beats.delete();
        if (err_latched) begin
            add_beat(KIND_ERR, 8'h00, TYPE_WORD);
            return;
        end
        if (eos_seen) begin
            add_beat(KIND_EOS, 8'h00, TYPE_WORD);
            return;
        end
        if (it.opcode == OP_END) begin
            if (quoted) begin
                latch_error();
                return;
            end
            if (tok_mode == MODE_WORD)
                add_beat(KIND_END, 8'h00, TYPE_WORD);
            add_beat(KIND_EOS, 8'h00, TYPE_WORD);
            clear_line();
            eos_seen = 1'b1;
            return;
        end
        if (c == CH_CR)
            return;
        if (c == CH_LF) begin
            if (quoted) begin
                latch_error();
                return;
            end
            if (tok_mode == MODE_WORD)
                add_beat(KIND_END, 8'h00, TYPE_WORD);
            clear_line();
            return;
        end
        if (hash_state == CD_COMMENT)
            return;
        if (c == CH_HASH && hash_state == CD_NONE) begin
            if (sq_odd || dq_odd)
                hash_state = CD_KEPT;
            else begin
                hash_state = CD_COMMENT;
                if (quoted) begin
                    latch_error();
                    return;
                end
                if (tok_mode == MODE_WORD)
                    add_beat(KIND_END, 8'h00, TYPE_WORD);
                tok_mode = MODE_IDLE;
                return;
            end
        end
        if (hash_state == CD_NONE) begin
            if (c == CH_SQUOTE)
                sq_odd = ~sq_odd;
            else if (c == CH_DQUOTE)
                dq_odd = ~dq_odd;
        end
        case (tok_mode)
            MODE_IDLE:
            begin
                if (is_blank(c))
                    return;
                if (c == CH_SQUOTE)
                    tok_mode = MODE_SQ;
                else if (c == CH_DQUOTE)
                    tok_mode = MODE_DQ;
                else if (c == CH_AT || is_delim(c)) begin
                    add_beat(KIND_CHAR, c, TYPE_DELIM);
                    add_beat(KIND_END, 8'h00, TYPE_DELIM);
                end
                else begin
                    tok_mode = MODE_WORD;
                    add_beat(KIND_CHAR, c, TYPE_WORD);
                end
            end
            MODE_WORD:
            begin
                if (is_blank(c)) begin
                    add_beat(KIND_END, 8'h00, TYPE_WORD);
                    tok_mode = MODE_IDLE;
                end
                else if (is_delim(c)) begin
                    add_beat(KIND_END, 8'h00, TYPE_WORD);
                    add_beat(KIND_CHAR, c, TYPE_DELIM);
                    add_beat(KIND_END, 8'h00, TYPE_DELIM);
                    tok_mode = MODE_IDLE;
                end
                else
                    add_beat(KIND_CHAR, c, TYPE_WORD);
            end
            default:
            begin
                if ((tok_mode == MODE_SQ && c == CH_SQUOTE) ||
                    (tok_mode == MODE_DQ && c == CH_DQUOTE)) begin
                    add_beat(KIND_END, 8'h00, TYPE_QUOTED);
                    tok_mode = MODE_IDLE;
                end
                else
                    add_beat(KIND_CHAR, c, TYPE_QUOTED);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_line();
            err_latched = 1'b0;
            eos_seen    = 1'b0;
            token_beats.delete();
            mismatches  = 0;
            results_due = 0;
        end
        else begin
            if (pop && !empty) begin
                if (token_beats.size() == 0) begin
                    $display("%0t: unexpected beat, kind %0d char 0x%0h type %0d last %0b",
                             $time, out_item.result_kind, out_item.token_char,
                             out_item.token_type, out_item.last_of_run);
                    mismatches++;
                end
                else begin
                    oldest = token_beats.pop_front();
                    check_field("result_kind", 8'(oldest.result_kind),
                                8'(out_item.result_kind));
                    check_field("token_char", oldest.token_char, out_item.token_char);
                    check_field("token_type", 8'(oldest.token_type),
                                8'(out_item.token_type));
                    check_field("last_of_run", 8'(oldest.last_of_run),
                                8'(out_item.last_of_run));
                end
            end
            if (push && !full) begin
                tokenize_step(in_item);
                if (byte_beats.size() > 0)
                    byte_beats[byte_beats.size() - 1].last_of_run = 1'b1;
                foreach (byte_beats[i])
                    token_beats.push_back(byte_beats[i]);
            end
            results_due = token_beats.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ctt_pkg::*;

    // Stream: a short directed prefix, then random lines to at least this many more bytes.
    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS   = 450;
    // Receiver backpressure: one long hold once this many bytes have gone in.
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 60;
    // The last bytes of the stream go in with no idle bursts on either side.
    localparam int QUIET_ITEMS    = 100;
    // After the last predicted beat, watch this long for strays before the verdict.
    localparam int DRAIN_CYCLES   = 8;
    // Longest legal stretch without a beat is the receiver hold; allow far more.
    localparam int STALL_LIMIT    = 1000;

    // Byte classes for the random text generator
    localparam int CLS_LEAD  = 0;   // first byte of a word
    localparam int CLS_WORD  = 1;   // later byte of a word
    localparam int CLS_TEXT  = 2;   // inside a quoted string or a comment
    localparam int CLS_NOISE = 3;   // anything that cannot open a string

    logic      clk;
    logic      rst_n = 1'b1;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;
    int        mismatches;
    int        results_due;

    in_item_t  text_stream[$];
    int        accepted_items = 0;
    int        quiet_from;
    int        stall_cycles;
    bit        held_off = 1'b0;

    config_text_tokenizer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    tokenizer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void put_byte(input logic [7:0] c);
        in_item_t it;
        it.opcode    = OP_DATA;
        it.text_byte = c;
        text_stream.push_back(it);
    endfunction

    // End of input; the byte field is don't-care, so randomize it.
    function automatic void put_end();
        in_item_t it;
        it.opcode    = OP_END;
        it.text_byte = 8'($urandom_range(0, 255));
        text_stream.push_back(it);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // Leading @ is a delimiter only between tokens, so callers closing a word pass 0.
    function automatic logic [7:0] pick_delim(input bit with_at);
        case ($urandom_range(0, with_at ? 7 : 6))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LPAREN;
            3:       return CH_RPAREN;
            4:       return CH_COMMA;
            5:       return CH_SEMI;
            6:       return CH_COLON;
            default: return CH_AT;
        endcase
    endfunction

    // Draw random bytes until one fits the class. No class lets a quote through,
    // so random text never leaves a string open and the error stays clear.
    function automatic logic [7:0] pick_byte(input int cls);
        logic [7:0] c;
        bit         sep;
        bit         quote;
        bit         ok;
        do begin
            c     = 8'($urandom_range(0, 255));
            sep   = c == CH_LF || c == CH_SPACE || c == CH_TAB || c == CH_VT ||
                    c == CH_FF || c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
                    c == CH_RPAREN || c == CH_COMMA || c == CH_SEMI || c == CH_COLON;
            quote = c == CH_SQUOTE || c == CH_DQUOTE;
            case (cls)
                CLS_LEAD: ok = !sep && !quote && c != CH_HASH && c != CH_AT && c != CH_CR;
                CLS_WORD: ok = !sep && !quote && c != CH_HASH;
                CLS_TEXT: ok = !quote && c != CH_LF;
                default:  ok = !quote;
            endcase
        end while (!ok);
        return c;
    endfunction

    // Stimulus: build the whole byte stream, release reset, then push it beat by beat.
    initial begin
        int         ntok;
        logic [7:0] q;
        push    = 1'b0;
        in_item = '0;
        rst_n  <= 1'b0;

        // Directed line: NUL and top-bit bytes in words, @ inside a word and as a
        // leading delimiter, every mid-line delimiter, an empty single-quoted string,
        // a quoted #, CR inside a string, every blank but space, a # made ordinary by that
        // decision, then a comment line holding a quote that must be ignored.
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_AT);
        put_byte(CH_LBRACE);
        put_byte(CH_AT);
        put_byte(CH_RBRACE);
        put_byte(CH_LPAREN);
        put_byte(CH_RPAREN);
        put_byte(CH_COMMA);
        put_byte(CH_SEMI);
        put_byte(CH_COLON);
        put_byte(CH_SQUOTE);
        put_byte(CH_SQUOTE);
        put_byte(CH_DQUOTE);
        put_byte(CH_HASH);
        put_byte(CH_CR);
        put_byte(CH_DQUOTE);
        put_byte(CH_TAB);
        put_byte(8'h80);
        put_byte(CH_VT);
        put_byte(CH_HASH);
        put_byte(CH_FF);
        put_byte(CH_LF);
        put_byte(CH_HASH);
        put_byte(CH_SQUOTE);
        put_byte(CH_LF);

        // Random part: mostly well-formed lines with random content, some noise lines.
        while (text_stream.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    put_byte(pick_byte(CLS_NOISE));
            end
            else begin
                ntok = $urandom_range(0, 6);
                for (int t = 0; t < ntok; t++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4:
                        begin
                            // Word; quotes inside come in pairs so the parity is even
                            // again at the word's end, and a # between them is kept.
                            put_byte(pick_byte(CLS_LEAD));
                            repeat ($urandom_range(0, 5)) begin
                                if ($urandom_range(0, 7) == 0) begin
                                    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                                    put_byte(q);
                                    put_byte($urandom_range(0, 3) == 0 ? CH_HASH
                                                                       : pick_byte(CLS_WORD));
                                    put_byte(q);
                                end
                                else
                                    put_byte(pick_byte(CLS_WORD));
                            end
                            // Close the word; the last one may be left to a # or the LF.
                            if (t < ntok - 1 || $urandom_range(0, 1))
                                put_byte($urandom_range(0, 1) ? pick_blank() : pick_delim(1'b0));
                        end
                        5, 6:
                        begin
                            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                            put_byte(q);
                            repeat ($urandom_range(0, 6))
                                put_byte(pick_byte(CLS_TEXT));
                            put_byte(q);
                        end
                        7, 8:
                            put_byte(pick_delim(1'b1));
                        default:
                        begin
                            repeat ($urandom_range(1, 3))
                                put_byte(pick_blank());
                            if ($urandom_range(0, 1))
                                put_byte(CH_CR);
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0) begin
                    put_byte(CH_HASH);
                    repeat ($urandom_range(0, 6))
                        put_byte(pick_byte(CLS_TEXT));
                end
            end
            put_byte(CH_LF);
        end

        // Finish the stream one of four ways; each leaves a sticky state behind.
        case ($urandom_range(0, 3))
            0:
            begin
                // open word closed by end of input, then end of stream
                put_byte(pick_byte(CLS_LEAD));
                put_end();
            end
            1:
            begin
                // single-quoted string still open at the line feed
                put_byte(CH_SQUOTE);
                put_byte(pick_byte(CLS_TEXT));
                put_byte(CH_LF);
            end
            2:
            begin
                // the string's quote evens the parity left by the word's, so this # opens a comment
                // while the double-quoted string is still open
                put_byte(pick_byte(CLS_LEAD));
                put_byte(CH_DQUOTE);
                put_byte(pick_blank());
                put_byte(CH_DQUOTE);
                put_byte(CH_HASH);
            end
            default:
            begin
                // double-quoted string still open at end of input
                put_byte(CH_DQUOTE);
                put_end();
            end
        endcase
        // Anything after the sticky state repeats it once per beat in.
        repeat (8) begin
            if ($urandom_range(0, 1))
                put_end();
            else
                put_byte(8'($urandom_range(0, 255)));
        end

        quiet_from = text_stream.size() - QUIET_ITEMS;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drive at the falling edge; a beat goes in at a rising edge with full low.
        foreach (text_stream[i]) begin
            if (accepted_items < quiet_from && $urandom_range(0, 4) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            push    <= 1'b1;
            in_item <= text_stream[i];
            @(posedge clk);
            while (full)
                @(posedge clk);
            accepted_items++;
            @(negedge clk);
        end
        push <= 1'b0;

        // Hold until every predicted beat is out, then watch a little longer for strays.
        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: pop with random idle bursts, one long hold to fill the block,
    // and no idling over the last part of the stream.
    initial begin
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held_off && accepted_items >= HOLD_AFTER) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pop <= 1'b1;
            end
            else if (accepted_items < quiet_from && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: count cycles with no beat on either side; drop the run when stuck.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
